### src/keypad_countdown_timer_macros.svh
// ----------------------------------------------------------------------------
// keypad countdown timer assertion macros
// concurrent assertion wrappers shared by the timer rtl
// ----------------------------------------------------------------------------
`ifndef KEYPAD_COUNTDOWN_TIMER_MACROS_SVH
`define KEYPAD_COUNTDOWN_TIMER_MACROS_SVH

// consequent checked in the same cycle
`define KCT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define KCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// types, constants and helper functions of the keypad countdown timer
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam logic [7:0] KEY_NONE  = 8'd255;
  localparam logic [7:0] KEY_ENTER = 8'd10;
  localparam logic [7:0] KEY_START = 8'd11;
  localparam logic [7:0] KEY_LOW   = 8'd12;
  localparam logic [7:0] KEY_MID   = 8'd13;
  localparam logic [7:0] KEY_HIGH  = 8'd14;
  localparam logic [7:0] KEY_CLEAR = 8'd15;

  localparam logic [7:0] SEG_L = 8'h38;

  localparam logic [7:0] RST_COUNT_PERIOD = 8'd19;
  localparam logic [7:0] RST_DEBOUNCE     = 8'd2;
  localparam logic [7:0] RST_LEVEL_LOW    = 8'h50;
  localparam logic [7:0] RST_LEVEL_MID    = 8'hA0;
  localparam logic [7:0] RST_LEVEL_HIGH   = 8'hFF;

  localparam int unsigned NUM_DIGITS = 6;
  localparam int unsigned BCD_DIGITS = 5;
  localparam int unsigned BIN_W      = 16;

  typedef enum logic [2:0] {
    CFG_COUNT_PERIOD = 3'd0,
    CFG_DEBOUNCE     = 3'd1,
    CFG_LEVEL_LOW    = 3'd2,
    CFG_LEVEL_MID    = 3'd3,
    CFG_LEVEL_HIGH   = 3'd4
  } kct_cfg_idx_e;

  typedef logic [BCD_DIGITS-1:0][3:0] kct_bcd_t;

  typedef struct packed {
    logic [7:0] count_period;
    logic [7:0] debounce;
    logic [7:0] level_low;
    logic [7:0] level_mid;
    logic [7:0] level_high;
  } kct_cfg_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][7:0] segs;
    logic [7:0]                 dac;
    logic [BIN_W-1:0]           remaining;
    logic                       running;
  } kct_result_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

### src/kct_bcd_conv.sv
// ----------------------------------------------------------------------------
// kct_bcd_conv
// combinational binary to bcd split by constant reciprocal multiplication
// ----------------------------------------------------------------------------
module kct_bcd_conv (
  input  logic [kct_pkg::BIN_W-1:0] value_i,
  output kct_pkg::kct_bcd_t         bcd_o
);
  import kct_pkg::*;

  localparam int unsigned PROD_W = 33;

  // reciprocals rounded up, exact for every 16-bit value
  localparam logic [PROD_W-1:0] RCP_10    = 33'd52429;
  localparam logic [PROD_W-1:0] RCP_100   = 33'd83887;
  localparam logic [PROD_W-1:0] RCP_1000  = 33'd67109;
  localparam logic [PROD_W-1:0] RCP_10000 = 33'd107375;

  logic [13:0] q_10;
  logic [9:0]  q_100;
  logic [6:0]  q_1000;
  logic [2:0]  q_10000;

  assign q_10    = 14'((PROD_W'(value_i) * RCP_10) >> 19);
  assign q_100   = 10'((PROD_W'(value_i) * RCP_100) >> 23);
  assign q_1000  = 7'((PROD_W'(value_i) * RCP_1000) >> 26);
  assign q_10000 = 3'((PROD_W'(value_i) * RCP_10000) >> 30);

  assign bcd_o[0] = 4'(value_i - {2'd0, q_10} * 16'd10);
  assign bcd_o[1] = 4'(q_10 - {4'd0, q_100} * 14'd10);
  assign bcd_o[2] = 4'(q_100 - {3'd0, q_1000} * 10'd10);
  assign bcd_o[3] = 4'(q_1000 - {4'd0, q_10000} * 7'd10);
  assign bcd_o[4] = {1'b0, q_10000};

endmodule

### src/kct_core.sv
// ----------------------------------------------------------------------------
// kct_core
// timer state: key debounce and decode, digit entry, prescaler and countdown
// ----------------------------------------------------------------------------
module kct_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 kind_i,
  input  logic [7:0]           key_code_i,
  input  kct_pkg::kct_cfg_t    cfg_i,
  output kct_pkg::kct_result_t result_o
);
  import kct_pkg::*;

  logic [7:0]                 cur_key_q, cur_key_d;
  logic [7:0]                 hold_q, hold_d;
  logic [7:0]                 acc_key_q, acc_key_d;
  logic [7:0]                 pre_q, pre_d;
  logic [BIN_W-1:0]           count_q, count_d;
  logic                       armed_q, armed_d;
  logic                       closed_q, closed_d;
  logic [NUM_DIGITS-1:0][7:0] segs_q, segs_d;
  logic [7:0]                 dac_q, dac_d;
  logic [BIN_W-1:0]           step_val;
  kct_bcd_t                   step_bcd;
  logic                       nz;

  // armed means entry is closed, so an item that steps never changes the count first
  assign step_val = count_q - BIN_W'(1);

  kct_bcd_conv u_bcd_conv (
    .value_i (step_val),
    .bcd_o   (step_bcd)
  );

  always_comb begin
    cur_key_d  = cur_key_q;
    hold_d     = hold_q;
    acc_key_d  = acc_key_q;
    pre_d      = pre_q;
    count_d    = count_q;
    armed_d    = armed_q;
    closed_d   = closed_q;
    segs_d     = segs_q;
    dac_d      = dac_q;
    nz         = 1'b0;
    if (accept_i) begin
      if (!kind_i) begin
        if (cur_key_q != KEY_NONE) begin
          if (hold_q != 8'hFF) begin
            hold_d = hold_q + 8'd1;
          end
        end else begin
          hold_d = '0;
        end
        if (pre_q != 8'd0 && pre_q != 8'hFF) begin
          pre_d = pre_q + 8'd1;
        end
      end else begin
        cur_key_d = key_code_i;
        if (hold_q > cfg_i.debounce && key_code_i != KEY_NONE && key_code_i != acc_key_q) begin
          if (key_code_i >= KEY_START && key_code_i <= KEY_CLEAR) begin
            acc_key_d = key_code_i;
            case (key_code_i)
              KEY_START: begin
                pre_d = (segs_q[NUM_DIGITS-1] == SEG_L) ? 8'd1 : 8'd0;
              end
              KEY_LOW:  dac_d = cfg_i.level_low;
              KEY_MID:  dac_d = cfg_i.level_mid;
              KEY_HIGH: dac_d = cfg_i.level_high;
              KEY_CLEAR: begin
                dac_d    = '0;
                count_d  = '0;
                closed_d = 1'b0;
                pre_d    = '0;
                armed_d  = 1'b0;
                segs_d   = '0;
              end
              default: ;
            endcase
          end else if (!closed_q) begin
            if (segs_q[NUM_DIGITS-1] != SEG_L) begin
              for (int j = 0; j < NUM_DIGITS - 1; j++) begin
                segs_d[j] = segs_q[j+1];
              end
            end
            if (key_code_i < KEY_ENTER) begin
              segs_d[NUM_DIGITS-1] = seg_of(key_code_i[3:0]);
              count_d              = count_q * 16'd10 + {8'd0, key_code_i};
            end else if (key_code_i == KEY_ENTER) begin
              segs_d[NUM_DIGITS-1] = SEG_L;
              armed_d              = 1'b1;
              closed_d             = 1'b1;
            end
            acc_key_d = key_code_i;
          end
        end
      end
      if (armed_d) begin
        if (count_d == '0) begin
          pre_d = '0;
        end else if (pre_d > cfg_i.count_period) begin
          pre_d   = 8'd1;
          count_d = step_val;
          for (int j = 0; j < BCD_DIGITS; j++) begin
            nz = nz | (step_bcd[BCD_DIGITS-1-j] != 4'd0);
            segs_d[j] = (nz || j == BCD_DIGITS - 1) ? seg_of(step_bcd[BCD_DIGITS-1-j]) : 8'd0;
          end
          if (count_d == '0) begin
            dac_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_key_q <= KEY_NONE;
      hold_q    <= '0;
      acc_key_q <= KEY_NONE;
      pre_q     <= '0;
      count_q   <= '0;
      armed_q   <= 1'b0;
      closed_q  <= 1'b0;
      segs_q    <= '0;
      dac_q     <= '0;
    end else begin
      cur_key_q <= cur_key_d;
      hold_q    <= hold_d;
      acc_key_q <= acc_key_d;
      pre_q     <= pre_d;
      count_q   <= count_d;
      armed_q   <= armed_d;
      closed_q  <= closed_d;
      segs_q    <= segs_d;
      dac_q     <= dac_d;
    end
  end

  assign result_o.segs      = segs_d;
  assign result_o.dac       = dac_d;
  assign result_o.remaining = count_d;
  assign result_o.running   = (pre_d != 8'd0);

endmodule

### src/kct_out_buf.sv
// ----------------------------------------------------------------------------
// kct_out_buf
// two-entry result buffer between the timer state and the output channel
// ----------------------------------------------------------------------------
module kct_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  kct_pkg::kct_result_t data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kct_pkg::kct_result_t data_o
);
  import kct_pkg::*;

  kct_result_t mem_q [2];
  logic [1:0]  cnt_q, cnt_d;
  logic        wr_q, rd_q;
  logic        pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;
  assign data_o      = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### src/keypad_countdown_timer.sv
// ----------------------------------------------------------------------------
// keypad_countdown_timer
// keypad-set countdown timer with seven-segment digits and a dac level
// ----------------------------------------------------------------------------
// One item (tick or key scan) is taken per clock and fully processed in that
// cycle, including the decimal digits of the count during countdown; its
// result is registered in a two-entry output buffer and offered on the output
// channel after any older results in it are taken. Items can follow back to
// back; the input stalls only while both buffer entries hold results that the
// output side has not yet taken.
`include "keypad_countdown_timer_macros.svh"

module keypad_countdown_timer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] key_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] seg_d0_o,
  output logic [7:0] seg_d1_o,
  output logic [7:0] seg_d2_o,
  output logic [7:0] seg_d3_o,
  output logic [7:0] seg_d4_o,
  output logic [7:0] seg_d5_o,
  output logic [7:0] dac_level_o,
  output logic [15:0] remaining_o,
  output logic       running_o
);
  import kct_pkg::*;

  kct_cfg_t      cfg_q;
  kct_result_t   result, out_data;
  logic          buf_full;
  logic          in_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count_period <= RST_COUNT_PERIOD;
      cfg_q.debounce     <= RST_DEBOUNCE;
      cfg_q.level_low    <= RST_LEVEL_LOW;
      cfg_q.level_mid    <= RST_LEVEL_MID;
      cfg_q.level_high   <= RST_LEVEL_HIGH;
    end else if (cfg_we_i) begin
      case (kct_cfg_idx_e'(cfg_idx_i))
        CFG_COUNT_PERIOD: cfg_q.count_period <= cfg_wdata_i;
        CFG_DEBOUNCE:     cfg_q.debounce     <= cfg_wdata_i;
        CFG_LEVEL_LOW:    cfg_q.level_low    <= cfg_wdata_i;
        CFG_LEVEL_MID:    cfg_q.level_mid    <= cfg_wdata_i;
        CFG_LEVEL_HIGH:   cfg_q.level_high   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = buf_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  kct_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .kind_i     (kind_i),
    .key_code_i (key_code_i),
    .cfg_i      (cfg_q),
    .result_o   (result)
  );

  kct_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .data_i      (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_data)
  );

  assign seg_d0_o    = out_data.segs[0];
  assign seg_d1_o    = out_data.segs[1];
  assign seg_d2_o    = out_data.segs[2];
  assign seg_d3_o    = out_data.segs[3];
  assign seg_d4_o    = out_data.segs[4];
  assign seg_d5_o    = out_data.segs[5];
  assign dac_level_o = out_data.dac;
  assign remaining_o = out_data.remaining;
  assign running_o   = out_data.running;

  // assertions
  `KCT_ASSERT_SAME(a_stall_when_full, clk_i, rst_ni, buf_full, in_stall_o, "input transfer while buffer full")
  `KCT_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_accept, out_valid_o, "input transfer left no result")
  `KCT_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data), "stalled result changed")

endmodule
